>>> sv/alp_pkg.sv
// ----------------------------------------------------------------------------
// alp_pkg
// Shared types and constants for the account line parser: field numbers,
// text field capacities, status codes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package alp_pkg;

	typedef logic [2:0] field_t;
	typedef logic [7:0] pos_t;
	typedef logic [7:0] char_t;
	typedef logic [31:0] id_t;

	localparam field_t FLD_NAME  = 3'd0;
	localparam field_t FLD_PASS  = 3'd1;
	localparam field_t FLD_UID   = 3'd2;
	localparam field_t FLD_GID   = 3'd3;
	localparam field_t FLD_GECOS = 3'd4;
	localparam field_t FLD_HOME  = 3'd5;
	localparam field_t FLD_SHELL = 3'd6;

	localparam int NAME_CAP  = 32;
	localparam int PASS_CAP  = 128;
	localparam int GECOS_CAP = 128;
	localparam int HOME_CAP  = 128;
	localparam int SHELL_CAP = 64;

	localparam id_t ID_LIMIT_RESET = 32'd2000000000;

	localparam char_t CH_HASH  = 8'h23;
	localparam char_t CH_COLON = 8'h3a;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_LF    = 8'h0a;
	localparam char_t CH_CR    = 8'h0d;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_COMMENT   = 3'd1,
		ST_FEW_FLDS  = 3'd2,
		ST_BAD_UID   = 3'd3,
		ST_BAD_GID   = 3'd4,
		ST_BAD_NAME  = 3'd5
	} status_t;

	// Capacity of a text field less one; the core stores only positions below it.
	function automatic pos_t field_last(input field_t f);
		pos_t r;
		case (f)
			FLD_NAME:  r = pos_t'(NAME_CAP - 1);
			FLD_PASS:  r = pos_t'(PASS_CAP - 1);
			FLD_GECOS: r = pos_t'(GECOS_CAP - 1);
			FLD_HOME:  r = pos_t'(HOME_CAP - 1);
			default:   r = pos_t'(SHELL_CAP - 1);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/account_line_parser_core.sv
// ----------------------------------------------------------------------------
// account_line_parser_core
// Byte-at-a-time parser for colon-separated seven-field account lines.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_ready    | line_end, char_in
//  out     | out_valid / out_ready  | field_index, field_pos, stored_byte, keep,
//          |                        | line_done, status, user_id, group_id
//  cfg     | cfg_wr_en              | cfg_wr_data (id_limit)
//
// Each beat lands in an input register, is parsed against the line state and
// goes to a result register; one beat per cycle is sustained while out_ready
// stays high. The single id digit unit (multiply by ten, add, compare to
// limit) sets the critical path. An output stall holds the result register
// and backs up into the input register. Reset clears line state and loads the
// default id limit.
// ----------------------------------------------------------------------------
`default_nettype none

module account_line_parser_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire alp_pkg::id_t     cfg_wr_data,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   line_end,
	input  wire alp_pkg::char_t   char_in,
	output logic                  out_valid,
	input  wire                   out_ready,
	output alp_pkg::field_t       field_index,
	output logic [6:0]            field_pos,
	output alp_pkg::char_t        stored_byte,
	output logic                  keep,
	output logic                  line_done,
	output logic [2:0]            status,
	output alp_pkg::id_t          user_id,
	output alp_pkg::id_t          group_id
);
	import alp_pkg::*;

	// input register
	logic   valid_s1;
	logic   line_end_s1;
	char_t  char_s1;

	// result register
	logic       valid_s2;
	field_t     field_s2;
	logic [6:0] pos_s2;
	char_t      byte_s2;
	logic       keep_s2;
	logic       done_s2;
	status_t    status_s2;
	id_t        uid_s2;
	id_t        gid_s2;

	// line state
	id_t    limit_q;
	field_t field_q;
	pos_t   pos_q;
	logic   started_q;
	logic   rejected_q;
	logic   stopped_q;
	id_t    uid_q;
	id_t    gid_q;
	logic   err_uid_q;
	logic   err_gid_q;
	logic   err_name_q;

	logic   advance;
	logic   out_free;

	// next state / result
	field_t  field_d;
	pos_t    pos_d;
	logic    started_d;
	logic    rejected_d;
	logic    stopped_d;
	id_t     uid_d;
	id_t     gid_d;
	logic    err_uid_d;
	logic    err_gid_d;
	logic    err_name_d;
	logic    keep_d;
	status_t status_d;
	pos_t    pos_bump;

	id_t  dig_acc;
	id_t  dig_next;
	logic dig_bad;

	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	assign dig_acc  = (field_q == FLD_UID) ? uid_q : gid_q;
	assign pos_bump = (pos_q == 8'hff) ? pos_q : pos_q + 8'd1;

	alp_id_digit u_digit (
		.acc      (dig_acc),
		.char_in  (char_s1),
		.id_limit (limit_q),
		.acc_next (dig_next),
		.bad      (dig_bad)
	);

	always_comb begin
		field_d    = field_q;
		pos_d      = pos_q;
		started_d  = started_q;
		rejected_d = rejected_q;
		stopped_d  = stopped_q;
		uid_d      = uid_q;
		gid_d      = gid_q;
		err_uid_d  = err_uid_q;
		err_gid_d  = err_gid_q;
		err_name_d = err_name_q;
		keep_d     = 1'b0;

		if (!started_q || rejected_q)
			status_d = ST_COMMENT;
		else if (field_q < FLD_SHELL)
			status_d = ST_FEW_FLDS;
		else if (err_uid_q)
			status_d = ST_BAD_UID;
		else if (err_gid_q)
			status_d = ST_BAD_GID;
		else if (err_name_q)
			status_d = ST_BAD_NAME;
		else
			status_d = ST_OK;

		if (line_end_s1) begin
			field_d    = FLD_NAME;
			pos_d      = '0;
			started_d  = 1'b0;
			rejected_d = 1'b0;
			stopped_d  = 1'b0;
			uid_d      = '0;
			gid_d      = '0;
			err_uid_d  = 1'b0;
			err_gid_d  = 1'b0;
			err_name_d = 1'b0;
		end else if (rejected_q) begin
			// rest of a comment line is dropped
		end else if (!started_q && (char_s1 == CH_SPACE || char_s1 == CH_TAB)) begin
			// leading blank
		end else if (!started_q && char_s1 == CH_HASH) begin
			started_d  = 1'b1;
			rejected_d = 1'b1;
		end else begin
			started_d = 1'b1;
			if (field_q < FLD_SHELL && char_s1 == CH_COLON) begin
				if (field_q == FLD_UID && pos_q == '0)
					err_uid_d = 1'b1;
				if (field_q == FLD_GID && pos_q == '0)
					err_gid_d = 1'b1;
				field_d = field_q + 3'd1;
				pos_d   = '0;
			end else if (field_q == FLD_UID) begin
				if (!err_uid_q) begin
					if (dig_bad)
						err_uid_d = 1'b1;
					else
						uid_d = dig_next;
				end
				pos_d = pos_bump;
			end else if (field_q == FLD_GID) begin
				if (!err_gid_q) begin
					if (dig_bad)
						err_gid_d = 1'b1;
					else
						gid_d = dig_next;
				end
				pos_d = pos_bump;
			end else if (field_q >= FLD_SHELL) begin
				if (!stopped_q) begin
					if (char_s1 == CH_CR || char_s1 == CH_LF) begin
						stopped_d = 1'b1;
					end else begin
						keep_d = (pos_q < field_last(FLD_SHELL));
						pos_d  = pos_bump;
					end
				end
			end else begin
				keep_d = (pos_q < field_last(field_q));
				if (keep_d && field_q == FLD_NAME && char_s1 == CH_LF)
					err_name_d = 1'b1;
				pos_d = pos_bump;
			end
		end
	end

	// control and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			limit_q    <= ID_LIMIT_RESET;
			field_q    <= FLD_NAME;
			pos_q      <= '0;
			started_q  <= 1'b0;
			rejected_q <= 1'b0;
			stopped_q  <= 1'b0;
			uid_q      <= '0;
			gid_q      <= '0;
			err_uid_q  <= 1'b0;
			err_gid_q  <= 1'b0;
			err_name_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				limit_q <= cfg_wr_data;
			if (in_ready)
				valid_s1 <= in_valid;
			if (out_free)
				valid_s2 <= valid_s1;
			if (advance) begin
				field_q    <= field_d;
				pos_q      <= pos_d;
				started_q  <= started_d;
				rejected_q <= rejected_d;
				stopped_q  <= stopped_d;
				uid_q      <= uid_d;
				gid_q      <= gid_d;
				err_uid_q  <= err_uid_d;
				err_gid_q  <= err_gid_d;
				err_name_q <= err_name_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			line_end_s1 <= line_end;
			char_s1     <= char_in;
		end
		if (advance) begin
			field_s2  <= field_q;
			pos_s2    <= pos_q[7] ? 7'h7f : pos_q[6:0];
			byte_s2   <= line_end_s1 ? 8'd0 : char_s1;
			keep_s2   <= keep_d;
			done_s2   <= line_end_s1;
			status_s2 <= line_end_s1 ? status_d : ST_OK;
			uid_s2    <= (line_end_s1 && status_d == ST_OK) ? uid_q : '0;
			gid_s2    <= (line_end_s1 && status_d == ST_OK) ? gid_q : '0;
		end
	end

	assign out_valid   = valid_s2;
	assign field_index = field_s2;
	assign field_pos   = pos_s2;
	assign stored_byte = byte_s2;
	assign keep        = keep_s2;
	assign line_done   = done_s2;
	assign status      = status_s2;
	assign user_id     = uid_s2;
	assign group_id    = gid_s2;

endmodule

`default_nettype wire

>>> sv/alp_id_digit.sv
// ----------------------------------------------------------------------------
// alp_id_digit
// One decimal digit step of an id: acc*10 + digit, checked for a digit and against the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module alp_id_digit (
	input  wire alp_pkg::id_t   acc,
	input  wire alp_pkg::char_t char_in,
	input  wire alp_pkg::id_t   id_limit,
	output alp_pkg::id_t        acc_next,
	output logic                bad
);
	import alp_pkg::*;

	logic        is_digit;
	logic [3:0]  digit;
	logic [35:0] prod;

	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign digit    = 4'(char_in - CH_ZERO);

	// acc*10 as acc*8 + acc*2; 36 bits hold the sum for any 32-bit acc
	assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, digit};

	assign acc_next = prod[31:0];
	assign bad      = !is_digit || (prod > {4'd0, id_limit});

endmodule

`default_nettype wire
